// ===== rtl/ets2c_pkg.sv =====
// ----------------------------------------------------------------------------
// ets2c_pkg
// Shared types and constants for the epoch seconds to calendar pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package ets2c_pkg;

  // cycles from an input transaction to its result transaction
  localparam int unsigned PIPE_LATENCY = 9;

  // whole days since the epoch and second of that day
  typedef struct packed {
    logic [21:0] days;
    logic [16:0] sod;
  } ets2c_day_t;

  // time of day and weekday
  typedef struct packed {
    logic [5:0] sec;
    logic [5:0] min;
    logic [4:0] hour;
    logic [2:0] wday;
  } ets2c_clock_t;

  // calendar date
  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  mon;
    logic [4:0]  mday;
  } ets2c_date_t;

endpackage

`default_nettype wire

// ===== rtl/ets2c_day_split.sv =====
// ----------------------------------------------------------------------------
// ets2c_day_split
// Clamps the signed second count and splits it into whole days and second of
// day, three register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module ets2c_day_split
  import ets2c_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               valid_i,
  input  logic signed [63:0] seconds_i,
  output logic               valid_o,
  output ets2c_day_t         day_o
);

  // first second past 9999-12-31 23:59:59
  localparam logic [62:0] SAT_LIMIT = 63'd253402300800;
  localparam logic [21:0] MAX_DAYS  = 22'd2932896;
  localparam logic [16:0] LAST_SOD  = 17'd86399;
  // ceil(2^41 / 675), exact quotient for 31-bit dividends
  localparam logic [31:0] R675 = 32'(((64'd1 << 41) + 64'd674) / 64'd675);

  logic        s0_valid_r, s1_valid_r, s2_valid_r;
  logic [30:0] s0_x_r, s1_x_r;
  logic [6:0]  s0_lo_r, s1_lo_r;
  logic        s0_sat_r, s1_sat_r;
  logic [21:0] s1_days_r;
  ets2c_day_t  s2_day_r;

  logic        neg;
  logic [62:0] div_prod;
  logic [30:0] rem_full;
  ets2c_day_t  s2_day_nxt;

  // clamp negatives, flag values beyond the last supported day
  assign neg = seconds_i[63];

  // t / 86400 = (t >> 7) / 675 by reciprocal multiply
  assign div_prod = 63'(s0_x_r) * 63'(R675);

  // remainder rebuilds the second of day, saturate past year 9999
  always_comb begin
    rem_full = s1_x_r - 31'(31'(s1_days_r) * 31'(675));
    if (s1_sat_r) begin
      s2_day_nxt.days = MAX_DAYS;
      s2_day_nxt.sod  = LAST_SOD;
    end else begin
      s2_day_nxt.days = s1_days_r;
      s2_day_nxt.sod  = {rem_full[9:0], s1_lo_r};
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s0_valid_r <= valid_i;
      s1_valid_r <= s0_valid_r;
      s2_valid_r <= s1_valid_r;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    s0_x_r    <= neg ? '0 : seconds_i[37:7];
    s0_lo_r   <= neg ? '0 : seconds_i[6:0];
    s0_sat_r  <= !neg && (seconds_i[62:0] >= SAT_LIMIT);
    s1_days_r <= div_prod[62:41];
    s1_x_r    <= s0_x_r;
    s1_lo_r   <= s0_lo_r;
    s1_sat_r  <= s0_sat_r;
    s2_day_r  <= s2_day_nxt;
  end

  assign valid_o = s2_valid_r;
  assign day_o   = s2_day_r;

endmodule

`default_nettype wire

// ===== rtl/ets2c_time_split.sv =====
// ----------------------------------------------------------------------------
// ets2c_time_split
// Hour, minute, second and weekday from the day split, six register stages
// to line up with the date path.
// ----------------------------------------------------------------------------
`default_nettype none

module ets2c_time_split
  import ets2c_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         valid_i,
  input  ets2c_day_t   day_i,
  output logic         valid_o,
  output ets2c_clock_t clock_o
);

  // exact reciprocals for the value ranges seen here
  localparam logic [17:0] R3600 = 18'(((64'd1 << 29) + 64'd3599) / 64'd3600);
  localparam logic [12:0] R60   = 13'(((64'd1 << 18) + 64'd59) / 64'd60);
  localparam logic [22:0] R7    = 23'(((64'd1 << 25) + 64'd6) / 64'd7);

  logic [5:0]   valid_r;

  logic [4:0]   a_hour_r;
  logic [16:0]  a_sod_r;
  logic [21:0]  a_v_r;
  logic [19:0]  a_q7_r;

  logic [4:0]   b_hour_r;
  logic [11:0]  b_rem_r;
  logic [2:0]   b_wday_r;

  logic [4:0]   c_hour_r;
  logic [11:0]  c_rem_r;
  logic [2:0]   c_wday_r;
  logic [5:0]   c_min_r;

  ets2c_clock_t d_clock_r, e_clock_r, f_clock_r;

  logic [21:0]  v_nxt;
  logic [34:0]  hour_prod;
  logic [44:0]  q7_prod;
  logic [16:0]  rem_full;
  logic [21:0]  wday_full;
  logic [24:0]  min_prod;
  logic [11:0]  sec_full;
  ets2c_clock_t d_clock_nxt;

  // stage a: hour and weekday quotient
  assign v_nxt     = day_i.days + 22'd4;
  assign hour_prod = 35'(day_i.sod) * 35'(R3600);
  assign q7_prod   = 45'(v_nxt) * 45'(R7);

  // stage b: remainder within the hour, weekday remainder
  assign rem_full  = a_sod_r - 17'(17'(a_hour_r) * 17'(3600));
  assign wday_full = a_v_r - 22'(22'(a_q7_r) * 22'(7));

  // stage c: minute
  assign min_prod  = 25'(b_rem_r) * 25'(R60);

  // stage d: second
  always_comb begin
    sec_full         = c_rem_r - 12'(12'(c_min_r) * 12'(60));
    d_clock_nxt.sec  = sec_full[5:0];
    d_clock_nxt.min  = c_min_r;
    d_clock_nxt.hour = c_hour_r;
    d_clock_nxt.wday = c_wday_r;
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= {valid_r[4:0], valid_i};
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    a_hour_r  <= hour_prod[33:29];
    a_sod_r   <= day_i.sod;
    a_v_r     <= v_nxt;
    a_q7_r    <= q7_prod[44:25];
    b_hour_r  <= a_hour_r;
    b_rem_r   <= rem_full[11:0];
    b_wday_r  <= wday_full[2:0];
    c_hour_r  <= b_hour_r;
    c_rem_r   <= b_rem_r;
    c_wday_r  <= b_wday_r;
    c_min_r   <= min_prod[23:18];
    d_clock_r <= d_clock_nxt;
    e_clock_r <= d_clock_r;
    f_clock_r <= e_clock_r;
  end

  assign valid_o = valid_r[5];
  assign clock_o = f_clock_r;

endmodule

`default_nettype wire

// ===== rtl/ets2c_date_split.sv =====
// ----------------------------------------------------------------------------
// ets2c_date_split
// Year, month and day of month from the day count, six register stages:
// year estimate counted from 1 March, leap-aware fix-up, month formula.
// ----------------------------------------------------------------------------
`default_nettype none

module ets2c_date_split
  import ets2c_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        valid_i,
  input  logic [21:0] days_i,
  output logic        valid_o,
  output ets2c_date_t date_o
);

  // days from 1 March 1 BC to the epoch, less the March shift
  localparam logic [21:0] MARCH_OFFSET = 22'd719468;
  // exact reciprocals for the value ranges seen here
  localparam logic [31:0] R146097 =
    32'(((64'd1 << 49) + 64'd146096) / 64'd146097);
  localparam logic [14:0] R100 = 15'(((64'd1 << 21) + 64'd99) / 64'd100);
  localparam logic [14:0] R400 = 15'(((64'd1 << 23) + 64'd399) / 64'd400);
  localparam logic [12:0] R306 = 13'(((64'd1 << 21) + 64'd305) / 64'd306);

  // first day of each month relative to 1 March, less one
  function automatic logic [8:0] month_start(input logic [3:0] mon);
    logic [8:0] s;
    begin
      case (mon)
        4'd1:    s = 9'd0;
        4'd2:    s = 9'd31;
        4'd3:    s = 9'd61;
        4'd4:    s = 9'd92;
        4'd5:    s = 9'd122;
        4'd6:    s = 9'd153;
        4'd7:    s = 9'd184;
        4'd8:    s = 9'd214;
        4'd9:    s = 9'd245;
        4'd10:   s = 9'd275;
        4'd11:   s = 9'd306;
        4'd12:   s = 9'd337;
        default: s = 9'd0;
      endcase
      return s;
    end
  endfunction

  logic [5:0]  valid_r;

  logic [21:0] a_d_r, b_d_r, c_d_r;
  logic [30:0] a_yarg_r;
  logic [13:0] b_year_r, c_year_r;
  logic [7:0]  c_q100_r;
  logic [5:0]  c_q400_r;
  logic [8:0]  d_yday_r, e_yday_r;
  logic [13:0] d_year_r, e_year_r;
  logic [3:0]  e_mon_r;
  ets2c_date_t f_date_r;

  logic [21:0]        d_nxt;
  logic [21:0]        dp2;
  logic [62:0]        year_prod;
  logic [28:0]        q100_prod;
  logic [28:0]        q400_prod;
  logic [22:0]        base;
  logic signed [23:0] yday_raw;
  logic signed [23:0] yday_adj;
  logic               leap;
  logic               is_c100;
  logic               is_c400;
  logic [8:0]         yday_nxt;
  logic [13:0]        year_nxt;
  logic [11:0]        mon_arg;
  logic [24:0]        mon_prod;
  logic [8:0]         mday_full;
  ets2c_date_t        f_date_nxt;

  // stage a: day number from 1 March 1 BC, scaled for the 400-year cycle
  assign d_nxt = days_i + MARCH_OFFSET;
  assign dp2   = d_nxt + 22'd2;

  // stage b: year estimate
  assign year_prod = 63'(a_yarg_r) * 63'(R146097);

  // stage c: century counts for the leap rule
  assign q100_prod = 29'(b_year_r) * 29'(R100);
  assign q400_prod = 29'(b_year_r) * 29'(R400);

  // stage d: day of year, step back a year when it comes out negative
  always_comb begin
    base = 23'(c_year_r) * 23'(365) + 23'(c_year_r[13:2])
         - 23'(c_q100_r) + 23'(c_q400_r);
    yday_raw = $signed({2'b00, c_d_r}) - $signed({1'b0, base});
    is_c100  = (c_year_r == 14'(14'(c_q100_r) * 14'(100)));
    is_c400  = (c_year_r == 14'(14'(c_q400_r) * 14'(400)));
    leap     = (c_year_r[1:0] == 2'b00) && (!is_c100 || is_c400);
    yday_adj = yday_raw + 24'sd365 + $signed({23'd0, leap});
    if (yday_raw < 0) begin
      yday_nxt = yday_adj[8:0];
      year_nxt = c_year_r - 14'd1;
    end else begin
      yday_nxt = yday_raw[8:0];
      year_nxt = c_year_r;
    end
  end

  // stage e: month counted from March
  assign mon_arg  = (12'(d_yday_r) + 12'd31) * 12'd10;
  assign mon_prod = 25'(mon_arg) * 25'(R306);

  // stage f: day of month, move to January-based month and year
  always_comb begin
    mday_full       = e_yday_r - month_start(e_mon_r) + 9'd1;
    f_date_nxt.mday = mday_full[4:0];
    if (e_yday_r >= 9'd306) begin
      f_date_nxt.mon  = e_mon_r - 4'd10;
      f_date_nxt.year = e_year_r + 14'd1;
    end else begin
      f_date_nxt.mon  = e_mon_r + 4'd2;
      f_date_nxt.year = e_year_r;
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= {valid_r[4:0], valid_i};
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    a_d_r    <= d_nxt;
    a_yarg_r <= 31'(dp2) * 31'(400);
    b_d_r    <= a_d_r;
    b_year_r <= year_prod[62:49];
    c_d_r    <= b_d_r;
    c_year_r <= b_year_r;
    c_q100_r <= q100_prod[28:21];
    c_q400_r <= q400_prod[28:23];
    d_yday_r <= yday_nxt;
    d_year_r <= year_nxt;
    e_yday_r <= d_yday_r;
    e_year_r <= d_year_r;
    e_mon_r  <= mon_prod[24:21];
    f_date_r <= f_date_nxt;
  end

  assign valid_o = valid_r[5];
  assign date_o  = f_date_r;

endmodule

`default_nettype wire

// ===== rtl/epoch_seconds_to_calendar_core.sv =====
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_core
// Signed seconds since 1970-01-01 UTC to Gregorian date, time and weekday.
// ----------------------------------------------------------------------------
// Usage:
//   Input: raise start with in_epoch_seconds; the transaction is taken at any
//   edge where start is high. busy stays low, so a new timestamp can enter in
//   every cycle, one transaction per clock sustained.
//   Output: out_strobe marks each result for a single cycle; the receiver
//   cannot hold it off, and nothing in the block waits on it.
//   Pipeline: three stages split seconds into days and second of day, six
//   more derive the calendar date (year estimate, leap fix-up, month
//   formula) while a parallel path derives hour, minute, second and
//   weekday.
//   Negative inputs read as the epoch; values past 9999-12-31 23:59:59
//   saturate to that instant.
//   Reset: synchronous, active low, empties the pipeline; there is no other
//   state, so nothing needs to be set up before use.
// ----------------------------------------------------------------------------
`default_nettype none

module epoch_seconds_to_calendar_core
  import ets2c_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [63:0] in_epoch_seconds,
  output logic               out_strobe,
  output logic [5:0]         out_second_of_minute,
  output logic [5:0]         out_minute_of_hour,
  output logic [4:0]         out_hour_of_day,
  output logic [4:0]         out_day_of_month,
  output logic [3:0]         out_month_of_year,
  output logic [13:0]        out_calendar_year,
  output logic [2:0]         out_day_of_week
);

  logic         day_valid;
  ets2c_day_t   day;
  logic         clock_valid;
  ets2c_clock_t clock_fields;
  logic         date_valid;
  ets2c_date_t  date_fields;

  // fully pipelined, never refuses a transaction
  assign busy = 1'b0;

  // seconds to days and second of day
  ets2c_day_split u_day_split (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_i   (start),
    .seconds_i (in_epoch_seconds),
    .valid_o   (day_valid),
    .day_o     (day)
  );

  // time of day and weekday
  ets2c_time_split u_time_split (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (day_valid),
    .day_i   (day),
    .valid_o (clock_valid),
    .clock_o (clock_fields)
  );

  // calendar date
  ets2c_date_split u_date_split (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (day_valid),
    .days_i  (day.days),
    .valid_o (date_valid),
    .date_o  (date_fields)
  );

  // result ports
  assign out_strobe           = date_valid;
  assign out_second_of_minute = clock_fields.sec;
  assign out_minute_of_hour   = clock_fields.min;
  assign out_hour_of_day      = clock_fields.hour;
  assign out_day_of_month     = date_fields.mday;
  assign out_month_of_year    = date_fields.mon;
  assign out_calendar_year    = date_fields.year;
  assign out_day_of_week      = clock_fields.wday;

  // both result paths stay in step
  assert property (@(posedge clk) disable iff (!rst_n)
    clock_valid == date_valid)
    else $error("time and date paths out of step");

  // every result comes from a transaction taken a fixed time earlier
  assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start, PIPE_LATENCY))
    else $error("result without a matching input");

  // negative input yields the epoch itself
  assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && $past(start && in_epoch_seconds[63], PIPE_LATENCY) |->
      out_calendar_year == 14'd1970 && out_month_of_year == 4'd1 &&
      out_day_of_month == 5'd1 && out_hour_of_day == 5'd0 &&
      out_minute_of_hour == 6'd0 && out_second_of_minute == 6'd0 &&
      out_day_of_week == 3'd4)
    else $error("negative input not clamped to the epoch");

  // far-future input saturates to the last second of 9999
  assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe &&
    $past(start && !in_epoch_seconds[63] && in_epoch_seconds[62:38] != 25'd0,
          PIPE_LATENCY) |->
      out_calendar_year == 14'd9999 && out_month_of_year == 4'd12 &&
      out_day_of_month == 5'd31 && out_hour_of_day == 5'd23 &&
      out_second_of_minute == 6'd59)
    else $error("far-future input not saturated");

  // calendar fields stay in range
  assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |->
      out_month_of_year >= 4'd1 && out_month_of_year <= 4'd12 &&
      out_day_of_month >= 5'd1 && out_day_of_week <= 3'd6 &&
      out_hour_of_day <= 5'd23)
    else $error("calendar field out of range");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the epoch seconds to calendar core against a behavioral calendar
// predictor: directed timestamps at the clamp, saturation, leap and century
// edges, then random timestamps weighted toward year and March boundaries.
// ----------------------------------------------------------------------------

module testbench;
  import ets2c_pkg::*;

  localparam longint unsigned SECS_PER_DAY   = 64'd86400;
  localparam longint unsigned LAST_DAY_INDEX = 64'd2932896;
  localparam longint unsigned LAST_SECOND    = 64'd86399;
  localparam longint unsigned MARCH_OFFSET   = 64'd59;
  localparam longint unsigned DAYS_FROM_0000 = 64'd719527;
  localparam longint unsigned DAYS_PER_ERA   = 64'd146097;
  localparam longint unsigned LAST_VALID_TS  = 64'd253402300799;
  localparam int              RANDOM_ITEMS   = 1250;
  localparam int              QUIET_TAIL     = 120;
  localparam int              CYCLE_LIMIT    = 200000;

  // one calendar breakdown
  typedef struct packed {
    logic [5:0]  sec;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  mday;
    logic [3:0]  month;
    logic [13:0] year;
    logic [2:0]  wday;
  } calendar_t;

  // pending timestamp, optionally held until the pipeline has drained
  typedef struct {
    logic signed [63:0] secs;
    bit                 drain_first;
  } stamp_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [63:0] in_epoch_seconds = '0;
  logic               out_strobe;
  logic [5:0]         out_second_of_minute;
  logic [5:0]         out_minute_of_hour;
  logic [4:0]         out_hour_of_day;
  logic [4:0]         out_day_of_month;
  logic [3:0]         out_month_of_year;
  logic [13:0]        out_calendar_year;
  logic [2:0]         out_day_of_week;

  stamp_t    pending_stamps[$];
  calendar_t expected_dates[$];
  bit        stamp_taken = 1'b0;
  int        error_count = 0;
  int        stamps_sent = 0;
  int        dates_checked = 0;
  int        clamped_count = 0;
  int        saturated_count = 0;
  int        cycle_count = 0;

  epoch_seconds_to_calendar_core DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_epoch_seconds     (in_epoch_seconds),
    .out_strobe           (out_strobe),
    .out_second_of_minute (out_second_of_minute),
    .out_minute_of_hour   (out_minute_of_hour),
    .out_hour_of_day      (out_hour_of_day),
    .out_day_of_month     (out_day_of_month),
    .out_month_of_year    (out_month_of_year),
    .out_calendar_year    (out_calendar_year),
    .out_day_of_week      (out_day_of_week)
  );

  // clock
  always #10 clk = ~clk;

  function automatic bit leap_year(longint unsigned yr);
    return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
  endfunction

  // predicted breakdown of one timestamp
  function automatic calendar_t to_calendar(logic signed [63:0] stamp);
    longint unsigned secs, day_count, sod, shifted, yr, era_base, mon, mday;
    longint          yday;
    calendar_t       c;
    secs = stamp[63] ? 64'd0 : stamp;
    day_count = secs / SECS_PER_DAY;
    sod = secs % SECS_PER_DAY;
    // saturate past the last day of year 9999
    if (day_count > LAST_DAY_INDEX) begin
      day_count = LAST_DAY_INDEX;
      sod = LAST_SECOND;
    end
    c.wday = 3'((4 + day_count) % 7);
    c.hour = 5'(sod / 3600);
    sod = sod % 3600;
    c.minute = 6'(sod / 60);
    c.sec = 6'(sod % 60);
    // year estimate counting from 1 March of year zero
    shifted = day_count - MARCH_OFFSET + DAYS_FROM_0000;
    yr = (shifted + 2) * 400 / DAYS_PER_ERA;
    era_base = 365 * yr + yr / 4 - yr / 100 + yr / 400;
    yday = longint'(shifted) - longint'(era_base);
    if (yday < 0) begin
      yday = 365 + yday + (leap_year(yr) ? 1 : 0);
      yr = yr - 1;
    end
    // month from day of the March-based year
    mon = (unsigned'(yday) + 31) * 10 / 306;
    mday = unsigned'(yday) - (367 * mon / 12 - 30) + 1;
    if (yday >= 306) begin
      yr = yr + 1;
      mon = mon - 10;
    end else begin
      mon = mon + 2;
    end
    c.mday = 5'(mday);
    c.month = 4'(mon);
    c.year = 14'(yr);
    return c;
  endfunction

  // first second of 1 January (or 1 March) of a year, plus a day offset
  function automatic longint unsigned year_mark(int unsigned yr, bit march, int day_shift);
    longint unsigned prev, day_index;
    prev = yr - 1;
    day_index = 365 * (yr - 1970) + prev / 4 - prev / 100 + prev / 400 - 477;
    if (march) day_index = day_index + 59 + leap_year(yr);
    return (day_index + longint'(day_shift)) * SECS_PER_DAY;
  endfunction

  function automatic logic signed [63:0] random_stamp();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6, 7, 8, 9:
        return raw % (LAST_VALID_TS + 1);
      10, 11, 12, 13:
        return year_mark($urandom_range(1971, 9999), $urandom_range(0, 1),
                         $urandom_range(0, 4) - 2) + $urandom_range(0, 86399);
      14, 15:
        return {1'b1, raw[62:0]};
      16, 17:
        return {1'b0, raw[62:0]};
      18:
        return raw[31:0];
      default:
        return raw;
    endcase
  endfunction

  task automatic queue_stamp(logic signed [63:0] secs, bit drain_first);
    stamp_t s;
    s.secs = secs;
    s.drain_first = drain_first;
    pending_stamps.push_back(s);
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      error_count++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  // driver: new transaction or idle cycle at each falling edge
  always @(negedge clk) begin : driver
    int gap_left;
    if (!rst_n) begin
      start <= 1'b0;
      gap_left = 0;
    end else if (start && !stamp_taken) begin
      // held transaction stays on the port until it is taken
    end else if (gap_left > 0) begin
      gap_left--;
      start <= 1'b0;
    end else if (pending_stamps.size() == 0) begin
      start <= 1'b0;
    end else if (pending_stamps[0].drain_first && expected_dates.size() != 0) begin
      start <= 1'b0;
    end else if (pending_stamps.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
      gap_left = $urandom_range(1, 10) - 1;
      start <= 1'b0;
    end else begin
      start <= 1'b1;
      in_epoch_seconds <= pending_stamps[0].secs;
      pending_stamps[0].drain_first = 1'b0;
    end
  end

  // monitor: check results, then record accepted transactions
  always @(posedge clk) begin : monitor
    calendar_t want;
    stamp_taken = 1'b0;
    if (rst_n && out_strobe) begin
      if (expected_dates.size() == 0) begin
        error_count++;
        $error("result transaction with nothing pending");
      end else begin
        want = expected_dates.pop_front();
        dates_checked++;
        check_field("second_of_minute", want.sec, out_second_of_minute);
        check_field("minute_of_hour", want.minute, out_minute_of_hour);
        check_field("hour_of_day", want.hour, out_hour_of_day);
        check_field("day_of_month", want.mday, out_day_of_month);
        check_field("month_of_year", want.month, out_month_of_year);
        check_field("calendar_year", want.year, out_calendar_year);
        check_field("day_of_week", want.wday, out_day_of_week);
      end
    end
    if (rst_n && start && !busy) begin
      expected_dates.push_back(to_calendar(in_epoch_seconds));
      if (in_epoch_seconds < 0) clamped_count++;
      else if (in_epoch_seconds > $signed(LAST_VALID_TS)) saturated_count++;
      void'(pending_stamps.pop_front());
      stamps_sent++;
      stamp_taken = 1'b1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    // directed: clamp, saturation, time-of-day, leap and century edges
    queue_stamp(64'sd0, 1'b0);
    queue_stamp(64'sd1, 1'b0);
    queue_stamp(-64'sd1, 1'b0);
    queue_stamp({1'b1, 63'd0}, 1'b0);
    queue_stamp({1'b0, {63{1'b1}}}, 1'b0);
    queue_stamp(64'sd59, 1'b0);
    queue_stamp(64'sd60, 1'b0);
    queue_stamp(64'sd3599, 1'b0);
    queue_stamp(64'sd3600, 1'b0);
    queue_stamp(64'sd86399, 1'b0);
    queue_stamp(64'sd86400, 1'b0);
    queue_stamp(year_mark(1971, 1'b0, 0) - 1, 1'b0);
    queue_stamp(year_mark(2000, 1'b1, 0) - 1, 1'b0);
    queue_stamp(year_mark(2000, 1'b1, 0), 1'b0);
    queue_stamp(year_mark(2100, 1'b1, 0) - 1, 1'b0);
    queue_stamp(year_mark(2100, 1'b1, 0), 1'b0);
    queue_stamp(year_mark(2001, 1'b0, 0), 1'b0);
    queue_stamp(64'sd2147483647, 1'b0);
    queue_stamp(64'sd2147483648, 1'b0);
    queue_stamp(LAST_DAY_INDEX * SECS_PER_DAY, 1'b0);
    queue_stamp(LAST_VALID_TS, 1'b0);
    queue_stamp(LAST_VALID_TS + 1, 1'b0);
    queue_stamp(64'h5555_5555_5555_5555, 1'b0);
    queue_stamp(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    // random part, pausing for a full drain now and then
    for (int i = 0; i < RANDOM_ITEMS; i++)
      queue_stamp(random_stamp(), (i % 400) == 200);

    // reset
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // wait for all stimulus and all results
    while (pending_stamps.size() != 0) @(posedge clk);
    while (expected_dates.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 4) @(posedge clk);

    $display("covered %0d timestamps: %0d clamped below the epoch, %0d saturated past 9999",
             stamps_sent, clamped_count, saturated_count);
    $display("%0d calendar results checked field by field", dates_checked);
    if (error_count == 0 && expected_dates.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ets2c_pkg.sv
rtl/ets2c_day_split.sv
rtl/ets2c_time_split.sv
rtl/ets2c_date_split.sv
rtl/epoch_seconds_to_calendar_core.sv
tb/testbench.sv
